FILE: hw/rtl/ulld_pkg.sv
// ----------------------------------------------------------------------------
// ulld_pkg
// Shared types, constants and transition functions of the units-language
// lexer automaton.
// ----------------------------------------------------------------------------
package ulld_pkg;

  localparam int unsigned CharWidth  = 7;
  localparam int unsigned StateWidth = 6;
  localparam int unsigned ClassWidth = 5;
  localparam int unsigned TdataInWidth  = 8;
  localparam int unsigned TdataOutWidth = 8;

  typedef logic [CharWidth-1:0]  char_t;
  typedef logic [StateWidth-1:0] state_t;

  typedef enum logic [ClassWidth-1:0] {
    ClsError   = 5'd0,
    ClsId      = 5'd1,
    ClsLum     = 5'd2,
    ClsLength  = 5'd3,
    ClsLess    = 5'd4,
    ClsTime    = 5'd5,
    ClsTemp    = 5'd6,
    ClsM       = 5'd7,
    ClsMass    = 5'd8,
    ClsMol     = 5'd9,
    ClsCd      = 5'd10,
    ClsCurrent = 5'd11,
    ClsAmount  = 5'd12,
    ClsA       = 5'd13,
    ClsS       = 5'd14,
    ClsKg      = 5'd15,
    ClsK       = 5'd16,
    ClsAssign  = 5'd17,
    ClsDefine  = 5'd18,
    ClsMult    = 5'd19,
    ClsPlus    = 5'd20,
    ClsSub     = 5'd21,
    ClsDiv     = 5'd22,
    ClsComment = 5'd23,
    ClsSpace   = 5'd24,
    ClsNumber  = 5'd25
  } token_class_e;

  typedef struct packed {
    token_class_e token_class;
    logic         dead;
  } result_t;

  // Automaton state codes
  localparam state_t StError   = 6'd0;
  localparam state_t StStart   = 6'd1;
  localparam state_t StKwFirst = 6'd2;
  localparam state_t StLum     = 6'd4;
  localparam state_t StLength  = 6'd9;
  localparam state_t StLess    = 6'd11;
  localparam state_t StTime    = 6'd15;
  localparam state_t StTemp    = 6'd18;
  localparam state_t StM       = 6'd19;
  localparam state_t StMass    = 6'd22;
  localparam state_t StMol     = 6'd24;
  localparam state_t StCd      = 6'd26;
  localparam state_t StCurrent = 6'd32;
  localparam state_t StAmount  = 6'd38;
  localparam state_t StUpperA  = 6'd39;
  localparam state_t StS       = 6'd40;
  localparam state_t StKg      = 6'd42;
  localparam state_t StUpperK  = 6'd43;
  localparam state_t StKwLast  = 6'd43;
  localparam state_t StAssign  = 6'd44;
  localparam state_t StColon   = 6'd45;
  localparam state_t StDefine  = 6'd46;
  localparam state_t StMult    = 6'd47;
  localparam state_t StPlus    = 6'd48;
  localparam state_t StSub     = 6'd49;
  localparam state_t StDiv     = 6'd50;
  localparam state_t StComment = 6'd51;
  localparam state_t StSpace   = 6'd52;
  localparam state_t StId      = 6'd53;
  localparam state_t StInt     = 6'd54;
  localparam state_t StFrac    = 6'd55;
  localparam state_t StBadNum  = 6'd56;

  // Character codes
  localparam char_t ChEq      = 7'h3D;
  localparam char_t ChColon   = 7'h3A;
  localparam char_t ChStar    = 7'h2A;
  localparam char_t ChPlus    = 7'h2B;
  localparam char_t ChMinus   = 7'h2D;
  localparam char_t ChSlash   = 7'h2F;
  localparam char_t ChHash    = 7'h23;
  localparam char_t ChSpace   = 7'h20;
  localparam char_t ChTab     = 7'h09;
  localparam char_t ChNewline = 7'h0A;
  localparam char_t ChDot     = 7'h2E;
  localparam char_t ChDigit0  = 7'h30;
  localparam char_t ChDigit9  = 7'h39;
  localparam char_t ChUpperA  = 7'h41;
  localparam char_t ChUpperZ  = 7'h5A;
  localparam char_t ChLowerA  = 7'h61;
  localparam char_t ChLowerZ  = 7'h7A;

  typedef struct packed {
    state_t src;
    char_t  ch;
    state_t dst;
  } kw_edge_t;

  localparam int unsigned NumKwEdges = 42;

  localparam kw_edge_t KwEdges [NumKwEdges] = '{
    '{6'd1,  7'h6C, 6'd2},  '{6'd2,  7'h75, 6'd3},  '{6'd3,  7'h6D, 6'd4},
    '{6'd2,  7'h65, 6'd5},  '{6'd5,  7'h6E, 6'd6},  '{6'd6,  7'h67, 6'd7},
    '{6'd7,  7'h74, 6'd8},  '{6'd8,  7'h68, 6'd9},  '{6'd5,  7'h73, 6'd10},
    '{6'd10, 7'h73, 6'd11}, '{6'd1,  7'h74, 6'd12}, '{6'd12, 7'h69, 6'd13},
    '{6'd13, 7'h6D, 6'd14}, '{6'd14, 7'h65, 6'd15}, '{6'd12, 7'h65, 6'd16},
    '{6'd16, 7'h6D, 6'd17}, '{6'd17, 7'h70, 6'd18}, '{6'd1,  7'h6D, 6'd19},
    '{6'd19, 7'h61, 6'd20}, '{6'd20, 7'h73, 6'd21}, '{6'd21, 7'h73, 6'd22},
    '{6'd19, 7'h6F, 6'd23}, '{6'd23, 7'h6C, 6'd24}, '{6'd1,  7'h63, 6'd25},
    '{6'd25, 7'h64, 6'd26}, '{6'd25, 7'h75, 6'd27}, '{6'd27, 7'h72, 6'd28},
    '{6'd28, 7'h72, 6'd29}, '{6'd29, 7'h65, 6'd30}, '{6'd30, 7'h6E, 6'd31},
    '{6'd31, 7'h74, 6'd32}, '{6'd1,  7'h61, 6'd33}, '{6'd33, 7'h6D, 6'd34},
    '{6'd34, 7'h6F, 6'd35}, '{6'd35, 7'h75, 6'd36}, '{6'd36, 7'h6E, 6'd37},
    '{6'd37, 7'h74, 6'd38}, '{6'd1,  7'h41, 6'd39}, '{6'd1,  7'h73, 6'd40},
    '{6'd1,  7'h6B, 6'd41}, '{6'd41, 7'h67, 6'd42}, '{6'd1,  7'h4B, 6'd43}
  };

  function automatic logic is_digit(char_t c);
    return (c >= ChDigit0) && (c <= ChDigit9);
  endfunction

  function automatic logic is_letter(char_t c);
    return ((c >= ChUpperA) && (c <= ChUpperZ)) || ((c >= ChLowerA) && (c <= ChLowerZ));
  endfunction

  // Keyword edge lookup: returns StError when no edge matches.
  function automatic state_t kw_next(state_t s, char_t c);
    state_t n;
    n = StError;
    for (int i = 0; i < NumKwEdges; i++) begin
      if ((KwEdges[i].src == s) && (KwEdges[i].ch == c)) begin
        n = n | KwEdges[i].dst;
      end
    end
    return n;
  endfunction

  function automatic state_t next_state(state_t s, char_t c);
    state_t kw;
    state_t n;
    kw = kw_next(s, c);
    n  = StError;
    if (s == StStart) begin
      priority if (c == ChEq)                                   n = StAssign;
      else if (c == ChColon)                                    n = StColon;
      else if (c == ChStar)                                     n = StMult;
      else if (c == ChPlus)                                     n = StPlus;
      else if (c == ChMinus)                                    n = StSub;
      else if (c == ChSlash)                                    n = StDiv;
      else if (c == ChHash)                                     n = StComment;
      else if (c == ChSpace || c == ChTab || c == ChNewline)    n = StSpace;
      else if (is_digit(c))                                     n = StInt;
      else if (kw != StError)                                   n = kw;
      else if (is_letter(c))                                    n = StId;
      else                                                      n = StError;
    end else if ((s >= StKwFirst) && (s <= StKwLast)) begin
      priority if (kw != StError)              n = kw;
      else if (is_letter(c) || is_digit(c))    n = StId;
      else                                     n = StError;
    end else begin
      unique case (s)
        StColon:   n = (c == ChEq) ? StDefine : StError;
        StComment: n = StComment;
        StId:      n = (is_letter(c) || is_digit(c)) ? StId : StError;
        StInt: begin
          priority if (is_digit(c)) n = StInt;
          else if (c == ChDot)      n = StFrac;
          else                      n = StError;
        end
        StFrac: begin
          priority if (is_digit(c)) n = StFrac;
          else if (c == ChDot)      n = StBadNum;
          else                      n = StError;
        end
        default:   n = StError;
      endcase
    end
    return n;
  endfunction

  function automatic token_class_e state_class(state_t s);
    token_class_e k;
    unique case (s)
      StLum:     k = ClsLum;
      StLength:  k = ClsLength;
      StLess:    k = ClsLess;
      StTime:    k = ClsTime;
      StTemp:    k = ClsTemp;
      StM:       k = ClsM;
      StMass:    k = ClsMass;
      StMol:     k = ClsMol;
      StCd:      k = ClsCd;
      StCurrent: k = ClsCurrent;
      StAmount:  k = ClsAmount;
      StUpperA:  k = ClsA;
      StS:       k = ClsS;
      StKg:      k = ClsKg;
      StUpperK:  k = ClsK;
      StAssign:  k = ClsAssign;
      StDefine:  k = ClsDefine;
      StMult:    k = ClsMult;
      StPlus:    k = ClsPlus;
      StSub:     k = ClsSub;
      StDiv:     k = ClsDiv;
      StComment: k = ClsComment;
      StSpace:   k = ClsSpace;
      StId:      k = ClsId;
      StInt:     k = ClsNumber;
      StFrac:    k = ClsNumber;
      default:   k = ((s >= StKwFirst) && (s <= StKwLast)) ? ClsId : ClsError;
    endcase
    return k;
  endfunction

endpackage

FILE: hw/rtl/ulld_dfa_core.sv
// ----------------------------------------------------------------------------
// ulld_dfa_core
// Lexer state register with its combinational transition and classification.
// ----------------------------------------------------------------------------
module ulld_dfa_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  ulld_pkg::char_t      char_code_i,
  input  logic                 restart_i,
  output ulld_pkg::result_t    result_o
);

  ulld_pkg::state_t state_q;
  ulld_pkg::state_t state_d;
  ulld_pkg::state_t cur_state;

  assign cur_state = restart_i ? ulld_pkg::StStart : state_q;
  assign state_d   = ulld_pkg::next_state(cur_state, char_code_i);

  assign result_o.token_class = ulld_pkg::state_class(state_d);
  assign result_o.dead        = (state_d == ulld_pkg::StError);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ulld_pkg::StStart;
    end else if (step_i) begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hw/rtl/unit_language_lexer_dfa.sv
// ----------------------------------------------------------------------------
// unit_language_lexer_dfa
// Character-at-a-time lexer automaton for a units language.
// ----------------------------------------------------------------------------
// One character enters per cycle while the output is not stalled; each
// yields one result transaction, held in the output register after its
// character in the input register. The rate is set by the lexer state loop:
// next state is computed combinationally from the registered character and
// the state register, so back-to-back characters never wait on each other.
// Backpressure stalls the input only when both stages are full.
// ----------------------------------------------------------------------------
module unit_language_lexer_dfa (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [ulld_pkg::TdataInWidth-1:0]    s_axis_tdata,   // [6:0] char_code, [7] zero
  input  logic                                 s_axis_tuser,   // [0] restart
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [ulld_pkg::TdataOutWidth-1:0]   m_axis_tdata    // [4:0] token_class, [5] dead,
                                                               // [7:6] zero
);

  logic              in_valid_q;
  ulld_pkg::char_t   char_q;
  logic              restart_q;
  logic              out_valid_q;
  ulld_pkg::result_t result_q;
  ulld_pkg::result_t result_d;
  logic              advance;

  // Move the registered character forward when the output stage is free.
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;

  ulld_dfa_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (in_valid_q && advance),
    .char_code_i (char_q),
    .restart_i   (restart_q),
    .result_o    (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      char_q    <= s_axis_tdata[ulld_pkg::CharWidth-1:0];
      restart_q <= s_axis_tuser;
    end
    if (advance && in_valid_q) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(ulld_pkg::TdataOutWidth - ulld_pkg::ClassWidth - 1){1'b0}},
                          result_q.dead, result_q.token_class};

endmodule

FILE: hw/rtl/ulld_checker.sv
// ----------------------------------------------------------------------------
// ulld_checker
// Port-level checks for the lexer automaton, bound to the top level.
// ----------------------------------------------------------------------------
module ulld_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result transaction changed while stalled");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[7:6] == 2'b00)
    else $error("tdata padding bits not zero");

  a_dead_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[5] |-> m_axis_tdata[4:0] == 5'd0)
    else $error("dead result with a non-error token class");

  a_class_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[4:0] <= 5'd25)
    else $error("token class out of range");

endmodule

bind unit_language_lexer_dfa ulld_checker u_ulld_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
